>>> rtl/elevator_floor_dispatch_assert.svh
// Assertion macros used by the elevator dispatch top level.
`ifndef ELEVATOR_FLOOR_DISPATCH_ASSERT_SVH
`define ELEVATOR_FLOOR_DISPATCH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("elevator dispatch: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define EFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("elevator dispatch: next-cycle check failed");

`endif

>>> rtl/efd_pkg.sv
// Package with the constants, codes and helper functions of the elevator dispatcher.
package efd_pkg;

   // Number of served floors and the fixed field widths.
   localparam int FloorCount = 4;
   localparam int FloorWidth = 2;
   localparam int MapWidth   = 4;
   localparam int HallWidth  = 3;
   localparam int HallSlots  = 6;
   localparam int CountWidth = $clog2(FloorCount + 1);

   typedef logic [FloorCount-1:0] floor_map_type;
   typedef logic [CountWidth-1:0] floor_count_type;

   // Event codes of the request word.
   typedef enum logic [1:0] {
      ACT_CAB    = 2'd0,
      ACT_HALL   = 2'd1,
      ACT_SENSOR = 2'd2
   } action_type;

   // Travel direction codes.
   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // One-hot bit of a floor, empty when the floor is not served.
   function automatic floor_map_type floor_bit(logic [FloorWidth-1:0] f);
      floor_map_type m;
      for (int i = 0; i < FloorCount; i++) begin
         m[i] = (int'(f) == i);
      end
      return m;
   endfunction

   // Floors strictly above f.
   function automatic floor_map_type mask_above(logic [FloorWidth-1:0] f);
      floor_map_type m;
      for (int i = 0; i < FloorCount; i++) begin
         m[i] = (i > int'(f));
      end
      return m;
   endfunction

   // Floors strictly below f.
   function automatic floor_map_type mask_below(logic [FloorWidth-1:0] f);
      floor_map_type m;
      for (int i = 0; i < FloorCount; i++) begin
         m[i] = (i < int'(f));
      end
      return m;
   endfunction

   // Number of set bits in a floor map.
   function automatic floor_count_type pop_count(floor_map_type m);
      floor_count_type n;
      n = '0;
      for (int i = 0; i < FloorCount; i++) begin
         n = n + CountWidth'(m[i]);
      end
      return n;
   endfunction

   // Floor that a hall slot belongs to: up calls at 0..2, down calls at 1..3.
   function automatic logic [FloorWidth-1:0] slot_floor(logic [HallWidth-1:0] slot);
      logic [FloorWidth-1:0] f;
      case (slot)
         3'd1, 3'd3: f = 2'd1;
         3'd2, 3'd4: f = 2'd2;
         3'd5:       f = 2'd3;
         default:    f = 2'd0;
      endcase
      return f;
   endfunction

endpackage

>>> rtl/efd_if.sv
// Handshake interfaces for the request and response channels of the dispatcher.
interface efd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [efd_pkg::FloorWidth-1:0] req_floor;
   logic [efd_pkg::HallWidth-1:0]  hall_index;
   logic       sensor_valid;
   logic [efd_pkg::FloorWidth-1:0] sensor_floor;

   modport source (output valid, action, req_floor, hall_index, sensor_valid, sensor_floor,
                   input ready);
   modport sink (input valid, action, req_floor, hall_index, sensor_valid, sensor_floor,
                 output ready);
endinterface

interface efd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] motor_dir;
   logic [efd_pkg::FloorWidth-1:0] floor_shown;
   logic       door_open;
   logic       floor_report;
   logic [efd_pkg::MapWidth-1:0]   pending_map;

   modport source (output valid, motor_dir, floor_shown, door_open, floor_report, pending_map,
                   input ready);
   modport sink (input valid, motor_dir, floor_shown, door_open, floor_report, pending_map,
                 output ready);
endinterface

>>> rtl/elevator_floor_dispatch.sv
// Top level of the single-car elevator floor dispatcher.
//
// Usage: every event (cab request, hall assignment or floor sensor sample)
// is sent as one word on the req channel; exactly one word comes back on
// the rsp channel with the direction, indicator floor, door flag, report
// flag and pending floor map after that event.
// The word is held in an input register, then the event logic updates the
// car state and loads the response register, which drives rsp.valid.
// Throughput is one word per cycle while the receiver is ready, since the
// state update reads the state the previous word left.
// When the receiver stalls, the response register holds its word and the
// input register can still take one more word; req.ready drops only when
// both are full.
// Synchronous reset clears the pending map, stops the car at floor zero,
// marks a floor report as due and empties both registers.
module elevator_floor_dispatch (
   input  logic      clock,
   input  logic      reset,
   efd_req_if.sink   req,
   efd_rsp_if.source rsp
);

`include "elevator_floor_dispatch_assert.svh"

   // Input register.
   logic                                 in_valid_ff;
   logic [1:0]                           in_action_ff;
   logic [efd_pkg::FloorWidth-1:0]       in_req_floor_ff;
   logic [efd_pkg::HallWidth-1:0]        in_hall_ff;
   logic                                 in_sensor_valid_ff;
   logic [efd_pkg::FloorWidth-1:0]       in_sensor_floor_ff;

   // Car state.
   efd_pkg::floor_map_type               pend_ff, pend_in;
   efd_pkg::dir_type                     dir_ff, dir_in;
   logic [efd_pkg::FloorWidth-1:0]       last_ff, last_in;
   logic                                 due_ff, due_in;

   // Response register.
   logic                                 out_valid_ff;
   efd_pkg::dir_type                     out_dir_ff;
   logic [efd_pkg::FloorWidth-1:0]       out_floor_ff;
   logic                                 out_door_ff, door_in;
   logic                                 out_report_ff, report_in;
   efd_pkg::floor_map_type               out_pend_ff;

   logic                                 advance;
   logic                                 take_req;
   efd_pkg::floor_map_type               hit_bit;
   efd_pkg::floor_count_type             up_count;
   efd_pkg::floor_count_type             down_count;

   // The response register frees up when empty or drained this cycle.
   assign advance  = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;
   assign take_req = req.valid && req.ready;

   // Event handling and dispatch for the word in the input register.
   always_comb begin
      pend_in   = pend_ff;
      dir_in    = dir_ff;
      last_in   = last_ff;
      due_in    = due_ff;
      door_in   = 1'b0;
      report_in = 1'b0;
      hit_bit   = efd_pkg::floor_bit(in_sensor_floor_ff);

      case (efd_pkg::action_type'(in_action_ff))
         efd_pkg::ACT_CAB: begin
            pend_in = pend_in | efd_pkg::floor_bit(in_req_floor_ff);
         end
         efd_pkg::ACT_HALL: begin
            if (int'(in_hall_ff) < efd_pkg::HallSlots) begin
               pend_in = pend_in | efd_pkg::floor_bit(efd_pkg::slot_floor(in_hall_ff));
            end
         end
         efd_pkg::ACT_SENSOR: begin
            if (!in_sensor_valid_ff) begin
               due_in = 1'b1;
            end else if (int'(in_sensor_floor_ff) < efd_pkg::FloorCount) begin
               last_in = in_sensor_floor_ff;
               if ((pend_in & hit_bit) != '0) begin
                  // Arrival at a pending floor: clear it, open the door.
                  pend_in = pend_in & ~hit_bit;
                  door_in = 1'b1;
                  if (pend_in == '0) begin
                     dir_in = efd_pkg::DIR_STOP;
                  end else if (dir_ff == efd_pkg::DIR_UP) begin
                     if ((pend_in & ~efd_pkg::mask_below(in_sensor_floor_ff)) == '0) begin
                        dir_in = efd_pkg::DIR_DOWN;
                     end
                  end else if (dir_ff == efd_pkg::DIR_DOWN) begin
                     if ((pend_in & ~efd_pkg::mask_above(in_sensor_floor_ff)) == '0) begin
                        dir_in = efd_pkg::DIR_UP;
                     end
                  end
               end else begin
                  report_in = due_ff;
               end
               due_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // A stopped car with work elsewhere goes toward the side with more pending floors; a tie goes down.
      up_count   = efd_pkg::pop_count(pend_in & efd_pkg::mask_above(last_in));
      down_count = efd_pkg::pop_count(pend_in & efd_pkg::mask_below(last_in));
      if (dir_in == efd_pkg::DIR_STOP && pend_in != '0) begin
         if (up_count == '0 && down_count == '0) begin
            dir_in = efd_pkg::DIR_STOP;
         end else if (up_count > down_count) begin
            dir_in = efd_pkg::DIR_UP;
         end else begin
            dir_in = efd_pkg::DIR_DOWN;
         end
      end
   end

   // Control state and car state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff      <= '0;
         dir_ff       <= efd_pkg::DIR_STOP;
         last_ff      <= '0;
         due_ff       <= 1'b1;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            pend_ff <= pend_in;
            dir_ff  <= dir_in;
            last_ff <= last_in;
            due_ff  <= due_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_action_ff       <= req.action;
         in_req_floor_ff    <= req.req_floor;
         in_hall_ff         <= req.hall_index;
         in_sensor_valid_ff <= req.sensor_valid;
         in_sensor_floor_ff <= req.sensor_floor;
      end
      if (advance && in_valid_ff) begin
         out_dir_ff    <= dir_in;
         out_floor_ff  <= last_in;
         out_door_ff   <= door_in;
         out_report_ff <= report_in;
         out_pend_ff   <= pend_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.motor_dir    = out_dir_ff;
   assign rsp.floor_shown  = out_floor_ff;
   assign rsp.door_open    = out_door_ff;
   assign rsp.floor_report = out_report_ff;
   assign rsp.pending_map  = efd_pkg::MapWidth'(out_pend_ff);

   // A moving car always has somewhere to go.
   `EFD_ASSERT_NOW(a_moving_has_work, clock, reset,
      dir_ff != efd_pkg::DIR_STOP, pend_ff != '0)
   // An opened door means the floor shown is no longer pending.
   `EFD_ASSERT_NOW(a_door_clears_floor, clock, reset,
      out_valid_ff && out_door_ff, (out_pend_ff & efd_pkg::floor_bit(out_floor_ff)) == '0)
   // A stopped response leaves nothing pending away from the floor shown.
   `EFD_ASSERT_NOW(a_stop_only_here, clock, reset,
      out_valid_ff && out_dir_ff == efd_pkg::DIR_STOP,
      (out_pend_ff & ~efd_pkg::floor_bit(out_floor_ff)) == '0)
   // A stalled response keeps the car state frozen for that cycle.
   `EFD_ASSERT_NEXT(a_stall_freezes_state, clock, reset,
      out_valid_ff && !rsp.ready, $stable(pend_ff) && $stable(dir_ff))

endmodule

>>> tb/efd_dispatch_check.sv
// Checker that predicts the dispatcher's response words and compares them with the block.
module efd_dispatch_check (
   input  logic clock,
   input  logic reset,
   efd_req_if   req_mon,
   efd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   waiting_count,
   output int   checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]          motor_dir;
      logic [efd_pkg::FloorWidth-1:0] floor_shown;
      logic                door_open;
      logic                floor_report;
      logic [efd_pkg::MapWidth-1:0] pending_map;
   } car_status_type;

   // Predicted car state, kept apart from the block.
   logic [efd_pkg::FloorCount-1:0] pending;
   efd_pkg::dir_type               heading;
   logic [efd_pkg::FloorWidth-1:0] seen_floor;
   logic                           report_due;

   // Response words predicted but not yet seen, oldest first.
   car_status_type predicted_status[$];

   // Number of pending floors in [lo, hi_excl).
   function automatic int floors_set(logic [efd_pkg::FloorCount-1:0] map, int lo, int hi_excl);
      int n;
      n = 0;
      for (int f = lo; f < hi_excl && f < efd_pkg::FloorCount; f++) begin
         if (map[f]) n++;
      end
      return n;
   endfunction

   task automatic report_mismatch(string what, logic [3:0] got, logic [3:0] want);
      $display("mismatch in %s at response %0d: got %0h, expected %0h",
               what, checked_count, got, want);
      fail_count++;
   endtask

   task automatic compare_field(string what, logic [3:0] got, logic [3:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Apply one event word to the predicted state and form the response it causes.
   task automatic advance_car(input logic [1:0] act,
                              input logic [efd_pkg::FloorWidth-1:0] cab_floor,
                              input logic [efd_pkg::HallWidth-1:0] slot, input logic at_floor,
                              input logic [efd_pkg::FloorWidth-1:0] sensed,
                              output car_status_type status);
      logic                           door;
      logic                           report;
      logic [efd_pkg::FloorWidth-1:0] hall_floor;
      int                             above;
      int                             below;
      door = 1'b0;
      report = 1'b0;
      case (act)
         efd_pkg::ACT_CAB: begin
            pending[cab_floor] = 1'b1;
         end
         efd_pkg::ACT_HALL: begin
            // Up calls sit at floors 0 to 2, down calls at floors 1 to 3.
            case (slot)
               3'd0:       hall_floor = 2'd0;
               3'd1, 3'd3: hall_floor = 2'd1;
               3'd2, 3'd4: hall_floor = 2'd2;
               default:    hall_floor = 2'd3;
            endcase
            if (int'(slot) < efd_pkg::HallSlots) pending[hall_floor] = 1'b1;
         end
         efd_pkg::ACT_SENSOR: begin
            if (!at_floor) begin
               report_due = 1'b1;
            end else begin
               seen_floor = sensed;
               if (pending[sensed]) begin
                  // Stop at a pending floor; keep going only if work lies ahead.
                  pending[sensed] = 1'b0;
                  if (pending == '0) begin
                     heading = efd_pkg::DIR_STOP;
                  end else if (heading == efd_pkg::DIR_UP) begin
                     if (floors_set(pending, int'(sensed), efd_pkg::FloorCount) == 0)
                        heading = efd_pkg::DIR_DOWN;
                  end else if (heading == efd_pkg::DIR_DOWN) begin
                     if (floors_set(pending, 0, int'(sensed) + 1) == 0)
                        heading = efd_pkg::DIR_UP;
                  end
                  door = 1'b1;
               end else begin
                  report = report_due;
               end
               report_due = 1'b0;
            end
         end
         default: ;
      endcase

      // A stopped car with work elsewhere picks the side with more pending floors; a tie picks down.
      if (heading == efd_pkg::DIR_STOP && pending != '0) begin
         above = floors_set(pending, int'(seen_floor) + 1, efd_pkg::FloorCount);
         below = floors_set(pending, 0, int'(seen_floor));
         if (above == 0 && below == 0) heading = efd_pkg::DIR_STOP;
         else if (above > below) heading = efd_pkg::DIR_UP;
         else heading = efd_pkg::DIR_DOWN;
      end

      status.motor_dir    = heading;
      status.floor_shown  = seen_floor;
      status.door_open    = door;
      status.floor_report = report;
      status.pending_map  = efd_pkg::MapWidth'(pending);
   endtask

   // Compare accepted responses first, then predict from accepted requests.
   always @(posedge clock) begin
      car_status_type got;
      car_status_type want;
      if (reset) begin
         pending = '0;
         heading = efd_pkg::DIR_STOP;
         seen_floor = '0;
         report_due = 1'b1;
         predicted_status.delete();
         fail_count = 0;
         checked_count = 0;
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got.motor_dir    = rsp_mon.motor_dir;
            got.floor_shown  = rsp_mon.floor_shown;
            got.door_open    = rsp_mon.door_open;
            got.floor_report = rsp_mon.floor_report;
            got.pending_map  = rsp_mon.pending_map;
            if (predicted_status.size() == 0) begin
               report_mismatch("word with nothing expected", got.pending_map, 4'h0);
            end else begin
               want = predicted_status.pop_front();
               compare_field("motor_dir", 4'(got.motor_dir), 4'(want.motor_dir));
               compare_field("floor_shown", 4'(got.floor_shown), 4'(want.floor_shown));
               compare_field("door_open", 4'(got.door_open), 4'(want.door_open));
               compare_field("floor_report", 4'(got.floor_report), 4'(want.floor_report));
               compare_field("pending_map", got.pending_map, want.pending_map);
            end
            checked_count++;
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            advance_car(req_mon.action, req_mon.req_floor, req_mon.hall_index,
                        req_mon.sensor_valid, req_mon.sensor_floor, want);
            predicted_status.push_back(want);
         end
      end
      waiting_count = predicted_status.size();
   end

endmodule

>>> tb/elevator_floor_dispatch_tb.sv
// Top of the dispatcher testbench: clock, reset, event stimulus, response stalls and verdict.
module elevator_floor_dispatch_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ClockPeriod = 4;
   localparam int          CycleLimit  = 400000;
   localparam int          RandomWords = 970;
   localparam logic [1:0]  ActUnused   = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;
   logic steady_phase = 1'b0;
   int   stall_left = 0;
   int   cycle_count = 0;
   int   words_sent = 0;
   int   directed_words = 0;
   int   fail_count;
   int   waiting_count;
   int   checked_count;

   efd_req_if req_if();
   efd_rsp_if rsp_if();

   elevator_floor_dispatch dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   efd_dispatch_check dispatch_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .fail_count    (fail_count),
      .waiting_count (waiting_count),
      .checked_count (checked_count)
   );

   assign rsp_if.ready = sink_ready;

   always #(ClockPeriod / 2) clock = ~clock;

   // Idle lengths: mostly short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 8);
      else return $urandom_range(15, 40);
   endfunction

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, waiting_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response side: random stalls; no new stall starts in steady phases.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= 1'b1;
         if (!steady_phase && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
   end

   // Offer one event word, after an optional idle gap, and wait for its acceptance.
   task automatic send_word(input logic [1:0] act,
                            input logic [efd_pkg::FloorWidth-1:0] cab_floor,
                            input logic [efd_pkg::HallWidth-1:0] slot, input logic at_floor,
                            input logic [efd_pkg::FloorWidth-1:0] sensed);
      int gap;
      if (!steady_phase && $urandom_range(0, 99) < 30) begin
         gap = pick_gap();
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.action       <= act;
      req_if.req_floor    <= cab_floor;
      req_if.hall_index   <= slot;
      req_if.sensor_valid <= at_floor;
      req_if.sensor_floor <= sensed;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      words_sent++;
   endtask

   initial begin
      int car_floor;
      int useful;
      int r;
      logic car_rising;
      logic car_at_floor;

      req_if.valid        <= 1'b0;
      req_if.action       <= efd_pkg::ACT_CAB;
      req_if.req_floor    <= '0;
      req_if.hall_index   <= '0;
      req_if.sensor_valid <= 1'b0;
      req_if.sensor_floor <= '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: report flag handling, ignored words, a full trip up, all hall slots.
      send_word(efd_pkg::ACT_SENSOR, 2'd3, 3'd7, 1'b0, 2'd3);
      send_word(efd_pkg::ACT_SENSOR, 2'd0, 3'd0, 1'b1, 2'd0);
      send_word(efd_pkg::ACT_SENSOR, 2'd0, 3'd0, 1'b1, 2'd0);
      send_word(ActUnused, 2'd3, 3'd5, 1'b1, 2'd2);
      send_word(efd_pkg::ACT_HALL, 2'd0, 3'd6, 1'b0, 2'd0);
      send_word(efd_pkg::ACT_HALL, 2'd3, 3'd7, 1'b1, 2'd3);
      send_word(efd_pkg::ACT_CAB, 2'd3, 3'd0, 1'b0, 2'd0);
      for (int f = 1; f < efd_pkg::FloorCount; f++) begin
         send_word(efd_pkg::ACT_SENSOR, 2'd0, 3'd0, 1'b0, 2'(f));
         send_word(efd_pkg::ACT_SENSOR, 2'd0, 3'd0, 1'b1, 2'(f));
      end
      for (int s = 0; s < efd_pkg::HallSlots; s++) begin
         send_word(efd_pkg::ACT_HALL, 2'd0, 3'(s), 1'b0, 2'd0);
      end
      for (int f = 0; f < efd_pkg::FloorCount; f++) begin
         send_word(efd_pkg::ACT_CAB, 2'(f), 3'd0, 1'b0, 2'd0);
      end
      send_word(efd_pkg::ACT_SENSOR, 2'd0, 3'd0, 1'b1, 2'd3);
      send_word(efd_pkg::ACT_SENSOR, 2'd0, 3'd0, 1'b1, 2'd0);
      send_word(efd_pkg::ACT_SENSOR, 2'd0, 3'd0, 1'b1, 2'd1);
      directed_words = words_sent;

      // Random: mostly a car moving floor by floor with requests in between.
      car_floor = 1;
      car_rising = 1'b1;
      car_at_floor = 1'b1;
      useful = 0;
      while (useful < RandomWords) begin
         steady_phase <= ((useful / 100) % 4 == 3);
         r = $urandom_range(0, 99);
         if (r < 25) begin
            send_word(efd_pkg::ACT_CAB, 2'($urandom), 3'($urandom), 1'($urandom),
                      2'($urandom));
            useful++;
         end else if (r < 40) begin
            if ($urandom_range(0, 9) == 0) begin
               send_word(efd_pkg::ACT_HALL, 2'($urandom), 3'($urandom_range(6, 7)),
                         1'($urandom), 2'($urandom));
            end else begin
               send_word(efd_pkg::ACT_HALL, 2'($urandom), 3'($urandom_range(0, 5)),
                         1'($urandom), 2'($urandom));
               useful++;
            end
         end else if (r < 92) begin
            if (car_at_floor) begin
               send_word(efd_pkg::ACT_SENSOR, 2'($urandom), 3'($urandom), 1'b0,
                         2'($urandom));
            end else begin
               if (car_floor == efd_pkg::FloorCount - 1) car_rising = 1'b0;
               else if (car_floor == 0) car_rising = 1'b1;
               else if ($urandom_range(0, 99) < 15) car_rising = !car_rising;
               car_floor = car_rising ? car_floor + 1 : car_floor - 1;
               send_word(efd_pkg::ACT_SENSOR, 2'($urandom), 3'($urandom), 1'b1,
                         2'(car_floor));
            end
            car_at_floor = !car_at_floor;
            useful++;
         end else if (r < 96) begin
            // Broken sequence: the sensor jumps to any floor.
            car_at_floor = 1'($urandom);
            if (car_at_floor) car_floor = $urandom_range(0, efd_pkg::FloorCount - 1);
            send_word(efd_pkg::ACT_SENSOR, 2'($urandom), 3'($urandom), car_at_floor,
                      2'(car_floor));
            useful++;
         end else begin
            send_word(ActUnused, 2'($urandom), 3'($urandom), 1'($urandom), 2'($urandom));
         end
      end
      req_if.valid <= 1'b0;
      steady_phase <= 1'b0;

      // Drain the responses, then a short tail for any stray word.
      while (waiting_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d event words (%0d directed), checked %0d response words.",
               words_sent, directed_words, checked_count);
      $display("Covered cab and hall requests, car trips and ignored words under random stalls.");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
